@@ rtl/pcpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pcpa_pkg;

    // Sizing of the allocator (PAGE_BYTES is a power of two)
    localparam int CPU_COUNT  = 8;
    localparam int PAGE_COUNT = 32768;
    localparam int PAGE_BYTES = 4096;

    localparam int CPU_W      = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int IDX_W      = $clog2(PAGE_COUNT);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int LINK_W     = IDX_W + 1;
    localparam int ALU_W      = 33;

    // Field widths fixed by the interface
    localparam int ADDR_W     = 32;
    localparam int CPU_IN_W   = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEM_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_LIMIT = 1'b1;

    localparam logic [ADDR_W-1:0] MEM_START_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] MEM_LIMIT_RST = 32'h8800_0000;

    // Request into the shared add/subtract unit
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } t_alu_rsp;

    // Write port of the link memory
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] data;
    } t_link_wr;

    // Reduce a requested CPU number into the range of existing CPUs
    function automatic logic [CPU_W-1:0] cpu_reduce(input logic [CPU_IN_W-1:0] v);
        logic [4:0] t;
        t = {2'b00, v};
        for (int i = 0; i < 8; i++) begin
            if (t >= 5'(CPU_COUNT)) begin
                t = t - 5'(CPU_COUNT);
            end
        end
        return CPU_W'(t);
    endfunction

endpackage

`default_nettype wire

@@ rtl/pcpa_addsub.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pcpa_addsub (
    input  pcpa_pkg::t_alu_req i_req,
    output pcpa_pkg::t_alu_rsp o_rsp
);
    import pcpa_pkg::*;

    logic [ALU_W-1:0] w_b;
    logic [ALU_W:0]   w_sum;

    // Subtract as a + ~b + 1; carry set means no borrow
    assign w_b   = i_req.sub ? ~i_req.b : i_req.b;
    assign w_sum = {1'b0, i_req.a} + {1'b0, w_b} + {{ALU_W{1'b0}}, i_req.sub};

    assign o_rsp.sum   = w_sum[ALU_W-1:0];
    assign o_rsp.carry = w_sum[ALU_W];

endmodule

`default_nettype wire

@@ rtl/pcpa_link_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pcpa_link_mem (
    input  wire                        i_clk,
    input  pcpa_pkg::t_link_wr         i_wr,
    input  wire                        i_rd_en,
    input  wire [pcpa_pkg::IDX_W-1:0]  i_rd_addr,
    output logic [pcpa_pkg::LINK_W-1:0] o_rd_data
);
    import pcpa_pkg::*;

    // Entry: {link valid, next page index}
    logic [LINK_W-1:0] r_mem [PAGE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/per_cpu_page_free_list_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Per-CPU page free-list allocator with stealing.
// Input channel (i_valid/o_ready) carries one request per beat: an allocate
// or a free, the requesting CPU and, for a free, the page byte address.
// Output channel (o_valid/i_ready) returns one result beat per request:
// status, allocated page address and the CPU list that supplied it.
// Config port: i_cfg_we writes i_cfg_wdata into mem_start (index 0) or
// mem_limit (index 1) at the clock edge; write only while idle.
// One request at a time runs through a small sequencer that drives a
// single 33-bit add/subtract unit. Every request first rounds mem_start up
// to the page base. An aligned free then takes 3 address checks, the last
// one also pushing the page; an unaligned free is refused in the rounding
// step. An allocate scans the heads one CPU per cycle from the requester,
// then reads the link memory and forms the address on the adder, or
// returns out of memory when every list is empty. The sequencer goes back
// to idle once the result is loaded into the output register, and only
// then takes the next request.
// Reset (synchronous, active low) empties all lists and restores the
// registers; the link memory is not cleared, each entry is written before
// it is read. A stalled receiver holds the result in the output register;
// the next request is still taken and parks finished until it drains.

module per_cpu_page_free_list_allocator (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire                               i_operation,
    input  wire  [pcpa_pkg::CPU_IN_W-1:0]     i_cpu,
    input  wire  [pcpa_pkg::ADDR_W-1:0]       i_address,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [pcpa_pkg::STATUS_W-1:0]     o_status,
    output logic [pcpa_pkg::ADDR_W-1:0]       o_page_address,
    output logic [pcpa_pkg::CPU_IN_W-1:0]     o_source_cpu,
    input  wire                               i_cfg_we,
    input  wire  [pcpa_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire  [pcpa_pkg::ADDR_W-1:0]       i_cfg_wdata
);
    import pcpa_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_BASE    = 4'd1;
    localparam logic [3:0] S_CHK_LO  = 4'd2;
    localparam logic [3:0] S_CHK_HI  = 4'd3;
    localparam logic [3:0] S_CHK_IDX = 4'd4;
    localparam logic [3:0] S_SCAN    = 4'd5;
    localparam logic [3:0] S_RD      = 4'd6;
    localparam logic [3:0] S_ADDR    = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]          r_state, n_state;

    // Configuration registers
    logic [ADDR_W-1:0]   r_mem_start;
    logic [ADDR_W-1:0]   r_mem_limit;

    // List heads, one per CPU
    logic [IDX_W-1:0]    r_head [CPU_COUNT];
    logic [CPU_COUNT-1:0] r_head_ok;

    // Request context
    logic                r_op;
    logic [ADDR_W-1:0]   r_addr;
    logic [CPU_W-1:0]    r_cpu_sel, n_cpu_sel;
    logic [CPU_W-1:0]    r_scan_cnt, n_scan_cnt;
    logic [ALU_W-1:0]    r_base, n_base;
    logic [IDX_W-1:0]    r_pg, n_pg;

    // Result being built
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic [CPU_IN_W-1:0] r_res_src, n_res_src;

    // Shared unit and link memory
    t_alu_req            w_alu_req;
    t_alu_rsp            w_alu_rsp;
    t_link_wr            w_link_wr;
    logic                w_rd_en;
    logic [LINK_W-1:0]   w_rd_data;

    // Head of the selected list
    logic [IDX_W-1:0]    w_head_sel;
    logic                w_head_ok_sel;
    logic                w_idx_big;
    logic                w_push;
    logic                w_pop;
    logic                w_out_load;

    assign w_head_sel    = r_head[r_cpu_sel];
    assign w_head_ok_sel = r_head_ok[r_cpu_sel];
    assign w_idx_big     = (w_alu_rsp.sum >> PAGE_SHIFT) >= ALU_W'(PAGE_COUNT);
    assign w_out_load    = (r_state == S_DONE) && (!o_valid || i_ready);

    assign o_ready = (r_state == S_IDLE);

    pcpa_addsub u_addsub (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    pcpa_link_mem u_link_mem (
        .i_clk     (i_clk),
        .i_wr      (w_link_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_head_sel),
        .o_rd_data (w_rd_data)
    );

    // Sequencer: pick the adder operands and the next step
    always_comb begin
        n_state      = r_state;
        n_cpu_sel    = r_cpu_sel;
        n_scan_cnt   = r_scan_cnt;
        n_base       = r_base;
        n_pg         = r_pg;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_res_src    = r_res_src;
        w_alu_req    = '{a: {1'b0, r_addr}, b: {1'b0, r_mem_start}, sub: 1'b1};
        w_push       = 1'b0;
        w_pop        = 1'b0;
        w_rd_en      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cpu_sel    = cpu_reduce(i_cpu);
                    n_scan_cnt   = '0;
                    n_res_status = ST_OK;
                    n_res_addr   = '0;
                    n_res_src    = '0;
                    n_state      = S_BASE;
                end
            end
            S_BASE: begin
                // Round mem_start up to the page size
                w_alu_req = '{a: {1'b0, r_mem_start},
                              b: ALU_W'(PAGE_BYTES - 1), sub: 1'b0};
                n_base = {w_alu_rsp.sum[ALU_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
                if (r_op == OP_FREE) begin
                    if (r_addr[PAGE_SHIFT-1:0] != '0) begin
                        n_res_status = ST_BAD_ADDR;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_CHK_LO;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_CHK_LO: begin
                // Borrow: below mem_start
                if (!w_alu_rsp.carry) begin
                    n_res_status = ST_BAD_ADDR;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_CHK_HI;
                end
            end
            S_CHK_HI: begin
                w_alu_req = '{a: {1'b0, r_addr}, b: {1'b0, r_mem_limit}, sub: 1'b1};
                // No borrow: at or above mem_limit
                if (w_alu_rsp.carry) begin
                    n_res_status = ST_BAD_ADDR;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_CHK_IDX;
                end
            end
            S_CHK_IDX: begin
                w_alu_req = '{a: {1'b0, r_addr}, b: r_base, sub: 1'b1};
                if (!w_alu_rsp.carry || w_idx_big) begin
                    n_res_status = ST_BAD_ADDR;
                end else begin
                    w_push = 1'b1;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (w_head_ok_sel) begin
                    w_rd_en = 1'b1;
                    n_pg    = w_head_sel;
                    n_state = S_RD;
                end else if (r_scan_cnt == CPU_W'(CPU_COUNT - 1)) begin
                    n_res_status = ST_NO_MEM;
                    n_state      = S_DONE;
                end else begin
                    // Advance round-robin to the next CPU
                    n_cpu_sel  = (r_cpu_sel == CPU_W'(CPU_COUNT - 1)) ? '0
                                 : r_cpu_sel + 1'b1;
                    n_scan_cnt = r_scan_cnt + 1'b1;
                end
            end
            S_RD: begin
                w_pop   = 1'b1;
                n_state = S_ADDR;
            end
            S_ADDR: begin
                w_alu_req  = '{a: r_base, b: ALU_W'(r_pg) << PAGE_SHIFT, sub: 1'b0};
                n_res_addr = w_alu_rsp.sum[ADDR_W-1:0];
                n_res_src  = CPU_IN_W'(r_cpu_sel);
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Push writes the old head behind the freed page
    always_comb begin
        w_link_wr.en   = w_push;
        w_link_wr.addr = w_alu_rsp.sum[PAGE_SHIFT +: IDX_W];
        w_link_wr.data = {w_head_ok_sel, w_head_sel};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head_ok   <= '0;
            r_mem_start <= MEM_START_RST;
            r_mem_limit <= MEM_LIMIT_RST;
            o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_MEM_START: r_mem_start <= i_cfg_wdata;
                    REG_MEM_LIMIT: r_mem_limit <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_push) begin
                r_head_ok[r_cpu_sel] <= 1'b1;
            end else if (w_pop) begin
                r_head_ok[r_cpu_sel] <= w_rd_data[LINK_W-1];
            end
            if (w_out_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op   <= i_operation;
            r_addr <= i_address;
        end
        r_cpu_sel    <= n_cpu_sel;
        r_scan_cnt   <= n_scan_cnt;
        r_base       <= n_base;
        r_pg         <= n_pg;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_res_src    <= n_res_src;
        if (w_push) begin
            r_head[r_cpu_sel] <= w_link_wr.addr;
        end else if (w_pop) begin
            r_head[r_cpu_sel] <= w_rd_data[IDX_W-1:0];
        end
        if (w_out_load) begin
            o_status       <= r_res_status;
            o_page_address <= r_res_addr;
            o_source_cpu   <= r_res_src;
        end
    end

`ifndef SYNTHESIS
    a_nomem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NO_MEM) |-> (o_page_address == '0) && (o_source_cpu == '0))
        else $error("out of memory result carries a page");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_BAD_ADDR) |-> (o_page_address == '0) && (o_source_cpu == '0))
        else $error("rejected free carries a page");

    a_rd_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> $past(r_state) == S_SCAN)
        else $error("link read without a scan hit");

    a_pop_needs_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && (n_state == S_RD) |-> w_head_ok_sel)
        else $error("pop from an empty list");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_DONE)
        else $error("result shown without a finished request");
`endif

endmodule

`default_nettype wire

@@ tb/sv/pcpa_shadow_pkg.sv @@
`timescale 1ns / 1ps

package pcpa_shadow_pkg;
    import pcpa_pkg::*;

    // One result beat as the allocator should return it
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   page_addr;
        logic [CPU_IN_W-1:0] src_cpu;
        int unsigned         tag;
    } t_grant;

    class page_pool_shadow;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] limit_addr;
        logic [IDX_W-1:0]  head_page [CPU_COUNT];
        bit                head_live [CPU_COUNT];
        logic [IDX_W-1:0]  next_page [PAGE_COUNT];
        bit                next_live [PAGE_COUNT];
        t_grant            pending_grants [$];
        int unsigned       requests;
        int unsigned       results;
        int unsigned       mismatches;
        int unsigned       n_taken;
        int unsigned       n_refused;
        int unsigned       n_own;
        int unsigned       n_stolen;
        int unsigned       n_empty;

        function new();
            start_addr = MEM_START_RST;
            limit_addr = MEM_LIMIT_RST;
            for (int c = 0; c < CPU_COUNT; c++) begin
                head_page[c] = '0;
                head_live[c] = 1'b0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
            if (idx == REG_MEM_START) begin
                start_addr = val;
            end else if (idx == REG_MEM_LIMIT) begin
                limit_addr = val;
            end
        endfunction

        // mem_start rounded up to a whole page, kept to 33 bits
        function logic [ALU_W-1:0] page_base();
            return ({1'b0, start_addr} + ALU_W'(PAGE_BYTES - 1)) & ~ALU_W'(PAGE_BYTES - 1);
        endfunction

        // Work out the result of one accepted request and advance the lists
        function void note_request(logic op, logic [CPU_IN_W-1:0] cpu,
                                   logic [ADDR_W-1:0] addr);
            t_grant           grant;
            logic [ALU_W-1:0] base;
            logic [ALU_W-1:0] offset;
            logic [ALU_W-1:0] full;
            logic [IDX_W-1:0] pg;
            int unsigned      home;
            int unsigned      c;
            bit               found;

            grant.status    = ST_OK;
            grant.page_addr = '0;
            grant.src_cpu   = '0;
            grant.tag       = requests;
            requests++;
            base  = page_base();
            home  = int'(cpu) % CPU_COUNT;
            found = 1'b0;

            if (op == OP_FREE) begin
                offset = ({1'b0, addr} - base) >> PAGE_SHIFT;
                if (addr[PAGE_SHIFT-1:0] != '0 || addr < start_addr || addr >= limit_addr ||
                    {1'b0, addr} < base || offset >= PAGE_COUNT) begin
                    grant.status = ST_BAD_ADDR;
                    n_refused++;
                end else begin
                    pg = offset[IDX_W-1:0];
                    next_page[pg]   = head_page[home];
                    next_live[pg]   = head_live[home];
                    head_page[home] = pg;
                    head_live[home] = 1'b1;
                    n_taken++;
                end
            end else begin
                // own list first, then walk upward and wrap
                for (int k = 0; k < CPU_COUNT && !found; k++) begin
                    c = (home + k) % CPU_COUNT;
                    if (head_live[c]) begin
                        pg           = head_page[c];
                        head_live[c] = next_live[pg];
                        head_page[c] = next_page[pg];
                        full = base + (ALU_W'(pg) << PAGE_SHIFT);
                        grant.page_addr = full[ADDR_W-1:0];
                        grant.src_cpu   = CPU_IN_W'(c);
                        found = 1'b1;
                        if (k == 0) n_own++;
                        else n_stolen++;
                    end
                end
                if (!found) begin
                    grant.status = ST_NO_MEM;
                    n_empty++;
                end
            end
            pending_grants.push_back(grant);
        endfunction

        task report_mismatch(string what);
            if (mismatches < 200) begin
                $display("MISMATCH: %s", what);
            end
            mismatches++;
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] page_addr,
                          logic [CPU_IN_W-1:0] src_cpu);
            t_grant want;
            if (pending_grants.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending, status %0d",
                                          status));
                return;
            end
            want = pending_grants.pop_front();
            results++;
            if (status !== want.status) begin
                report_mismatch($sformatf("request %0d status %0d, want %0d",
                                          want.tag, status, want.status));
            end
            if (page_addr !== want.page_addr) begin
                report_mismatch($sformatf("request %0d page address %h, want %h",
                                          want.tag, page_addr, want.page_addr));
            end
            if (src_cpu !== want.src_cpu) begin
                report_mismatch($sformatf("request %0d source cpu %0d, want %0d",
                                          want.tag, src_cpu, want.src_cpu));
            end
        endtask
    endclass

endpackage

@@ tb/sv/per_cpu_page_free_list_allocator_test.sv @@
`timescale 1ns / 1ps

module per_cpu_page_free_list_allocator_test;
    import pcpa_pkg::*;
    import pcpa_shadow_pkg::*;

    localparam int QUIET_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 24;    // well past the longest request
    localparam int IDLE_PCT     = 17;
    localparam int PHASES       = 8;
    localparam int POOL_PAGES   = 48;    // pages recycled by most frees

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_operation;
    logic [CPU_IN_W-1:0]  i_cpu;
    logic [ADDR_W-1:0]    i_address;
    logic                 o_valid;
    logic                 i_ready;
    logic [STATUS_W-1:0]  o_status;
    logic [ADDR_W-1:0]    o_page_address;
    logic [CPU_IN_W-1:0]  o_source_cpu;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [ADDR_W-1:0]    i_cfg_wdata;

    page_pool_shadow shadow;
    bit              rst_done     = 1'b0;
    bit              steady       = 1'b0;  // no idling on either side
    bit              want_backlog = 1'b0;  // ask the receiver for a long hold-off
    int unsigned     windows      = 0;
    int unsigned     quiet        = 0;

    per_cpu_page_free_list_allocator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_cpu          (i_cpu),
        .i_address      (i_address),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_page_address (o_page_address),
        .o_source_cpu   (o_source_cpu),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one request beat, with a random gap ahead of it, and hold it until
    // it is taken. Valid stays high on return so back-to-back beats need no
    // second assignment in the same step.
    task automatic send_request(input logic op, input logic [CPU_IN_W-1:0] cpu,
                                input logic [ADDR_W-1:0] addr);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_cpu       <= cpu;
        i_address   <= addr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        shadow.note_request(op, cpu, addr);
    endtask

    // Drop valid and wait until every pending result beat has been checked
    task automatic settle_outputs();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.pending_grants.size() != 0);
    endtask

    // Write both window registers on back-to-back edges; the block is idle here
    task automatic program_window(input logic [ADDR_W-1:0] start_val,
                                  input logic [ADDR_W-1:0] limit_val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_MEM_START;
        i_cfg_wdata <= start_val;
        @(posedge i_clk);
        shadow.set_reg(REG_MEM_START, start_val);
        i_cfg_addr  <= REG_MEM_LIMIT;
        i_cfg_wdata <= limit_val;
        @(posedge i_clk);
        shadow.set_reg(REG_MEM_LIMIT, limit_val);
        i_cfg_we    <= 1'b0;
        windows++;
    endtask

    // Pick a free address: mostly a page from a small pool inside the window,
    // the rest the window edges, past capacity, below start, unaligned or noise
    function automatic logic [ADDR_W-1:0] pick_address(input int unsigned pool);
        logic [ALU_W-1:0] base;
        logic [ALU_W-1:0] span;
        logic [ALU_W-1:0] cand;
        int unsigned      top;
        int unsigned      lim;
        int unsigned      roll;

        base = shadow.page_base();
        top  = 0;
        if ({1'b0, shadow.limit_addr} > base) begin
            span = ({1'b0, shadow.limit_addr} - base - 1) >> PAGE_SHIFT;
            top  = (span > PAGE_COUNT - 1) ? PAGE_COUNT - 1 : int'(span);
        end
        lim  = (top < pool) ? top : pool;
        roll = $urandom_range(99);
        if (roll < 70) begin
            cand = base + (ALU_W'($urandom_range(lim)) << PAGE_SHIFT);
        end else if (roll < 75) begin
            cand = base + (ALU_W'(top) << PAGE_SHIFT);
        end else if (roll < 79) begin
            cand = {1'b0, shadow.limit_addr};
        end else if (roll < 83) begin
            cand = base + (ALU_W'(PAGE_COUNT) << PAGE_SHIFT);
        end else if (roll < 87) begin
            cand = base - ALU_W'(PAGE_BYTES);
        end else if (roll < 93) begin
            cand = base + (ALU_W'($urandom_range(lim)) << PAGE_SHIFT)
                 + ALU_W'($urandom_range(PAGE_BYTES - 1, 1));
        end else begin
            cand = {1'b0, $urandom()};
        end
        return cand[ADDR_W-1:0];
    endfunction

    task automatic run_random(input int unsigned count, input int unsigned free_pct,
                              input logic [CPU_IN_W-1:0] donor);
        logic                op;
        logic [CPU_IN_W-1:0] cpu;
        logic [ADDR_W-1:0]   addr;
        repeat (count) begin
            op   = ($urandom_range(99) < free_pct) ? OP_FREE : OP_ALLOC;
            cpu  = CPU_IN_W'($urandom_range(CPU_COUNT - 1));
            addr = $urandom();
            if (op == OP_FREE) begin
                // feed one list harder so the others run dry and steal from it
                if ($urandom_range(2) == 0) cpu = donor;
                addr = pick_address(POOL_PAGES);
            end
            send_request(op, cpu, addr);
        end
    endtask

    // Window, length and free share of each random phase
    task automatic phase_plan(input int p, output logic [ADDR_W-1:0] start_val,
                              output logic [ADDR_W-1:0] limit_val,
                              output int unsigned count, output int unsigned free_pct);
        case (p)
            0: begin
                start_val = MEM_START_RST; limit_val = MEM_LIMIT_RST;
                count = 300; free_pct = 55;
            end
            1: begin
                start_val = 32'h0000_0000; limit_val = 32'hFFFF_FFFF;
                count = 300; free_pct = 50;
            end
            2: begin
                start_val = 32'h1234_5678; limit_val = 32'h1236_0000;
                count = 250; free_pct = 50;
            end
            3: begin
                start_val = 32'hFFFF_F000; limit_val = 32'hFFFF_FFFF;
                count = 150; free_pct = 40;
            end
            4: begin
                start_val = 32'hFFFF_FFFF; limit_val = 32'h0000_0000;
                count = 150; free_pct = 30;
            end
            5: begin
                start_val = 32'h0000_0001; limit_val = 32'h0000_9000;
                count = 250; free_pct = 50;
            end
            6: begin
                start_val = $urandom();
                limit_val = start_val + $urandom_range(200, 1) * PAGE_BYTES;
                count = 300; free_pct = 45;
            end
            default: begin
                start_val = MEM_START_RST; limit_val = MEM_LIMIT_RST;
                count = 225; free_pct = 60;
            end
        endcase
    endtask

    // Receiver: check every result beat, idle at random, and hold off for a
    // long stretch when asked so the block backs up into its input.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        i_ready   = 1'b0;
        wait (rst_done);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                shadow.check_result(o_status, o_page_address, o_source_cpu);
            end
            if (want_backlog) begin
                want_backlog = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long
    initial begin
        wait (rst_done);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] start_val;
        logic [ADDR_W-1:0] limit_val;
        int unsigned       count;
        int unsigned       free_pct;

        shadow      = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = OP_ALLOC;
        i_cpu       = '0;
        i_address   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = REG_MEM_START;
        i_cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        // Directed: empty pool, window edges, refusals, double free, steals
        // and the full wrap of the scan, under the reset window.
        send_request(OP_ALLOC, 3'd0, 32'h0000_0000);
        send_request(OP_ALLOC, 3'd7, 32'hFFFF_FFFF);
        send_request(OP_FREE,  3'd0, MEM_START_RST);
        send_request(OP_FREE,  3'd7, MEM_LIMIT_RST - PAGE_BYTES);
        send_request(OP_FREE,  3'd3, MEM_LIMIT_RST);
        send_request(OP_FREE,  3'd1, MEM_START_RST - PAGE_BYTES);
        send_request(OP_FREE,  3'd2, MEM_START_RST + 1);
        send_request(OP_FREE,  3'd7, 32'hFFFF_FFFF);
        send_request(OP_FREE,  3'd0, 32'h0000_0000);
        send_request(OP_FREE,  3'd0, MEM_START_RST + PAGE_BYTES);
        // same page again onto another list: both lists now hold it
        send_request(OP_FREE,  3'd5, MEM_START_RST + PAGE_BYTES);
        send_request(OP_ALLOC, 3'd0, 32'h0000_0000);
        send_request(OP_ALLOC, 3'd6, 32'h0000_0000);
        send_request(OP_ALLOC, 3'd6, 32'h0000_0000);
        send_request(OP_ALLOC, 3'd6, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 3'd2, 32'h0000_0000);
        send_request(OP_FREE,  3'd7, MEM_START_RST + 2 * PAGE_BYTES);
        // scan has to walk all the way round to the last list
        send_request(OP_ALLOC, 3'd0, 32'h0000_0000);

        // Full 32-bit window: frees past the page capacity are refused
        settle_outputs();
        program_window(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_FREE, 3'd4, PAGE_COUNT * PAGE_BYTES);
        send_request(OP_FREE, 3'd4, (PAGE_COUNT - 1) * PAGE_BYTES);
        send_request(OP_FREE, 3'd1, 3 * PAGE_BYTES);

        // Move the start while pages are listed: the page base rolls past
        // 32 bits and the returned addresses wrap
        settle_outputs();
        program_window(32'hFFFF_F001, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 3'd1, 32'h0000_0000);
        send_request(OP_ALLOC, 3'd1, 32'h0000_0000);

        for (int p = 0; p < PHASES; p++) begin
            settle_outputs();
            phase_plan(p, start_val, limit_val, count, free_pct);
            program_window(start_val, limit_val);
            steady = (p == 5);
            if (p == 1) want_backlog = 1'b1;
            run_random(count, free_pct, CPU_IN_W'(p));
        end
        steady = 1'b0;

        settle_outputs();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests over %0d windows: %0d frees taken, %0d refused",
                 shadow.requests, windows, shadow.n_taken, shadow.n_refused);
        $display("Allocations: %0d own list, %0d stolen, %0d out of memory; %0d mismatches",
                 shadow.n_own, shadow.n_stolen, shadow.n_empty, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.pending_grants.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
